>>> rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants of the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

   localparam int DIM_X_DEF   = 16;
   localparam int DIM_Y_DEF   = 16;
   localparam int DIM_Z_DEF   = 16;

   localparam int CRD_W       = 4;
   localparam int BTYPE_W     = 8;
   localparam int WORD_W      = 32;
   localparam int FACE_W      = 3;
   localparam int NUM_FACES   = 6;
   // widest cell index over the allowed chunk sizes (64 x 256 x 64)
   localparam int IDX_MAX_W   = 20;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = CSR_IDX_W'(2);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [FACE_W-1:0] {
      FACE_LEFT   = 3'd0,
      FACE_RIGHT  = 3'd1,
      FACE_BOTTOM = 3'd2,
      FACE_TOP    = 3'd3,
      FACE_BACK   = 3'd4,
      FACE_FRONT  = 3'd5
   } face_type;

   typedef struct packed {
      op_type                 op;
      logic [IDX_MAX_W-1:0]   idx;
      logic [CRD_W-1:0]       x;
      logic [CRD_W-1:0]       y;
      logic [CRD_W-1:0]       z;
      logic                   solid;
      logic [BTYPE_W-1:0]     btype;
      logic [NUM_FACES-1:0]   on_bound;   // face lies on the chunk boundary
   } item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] z;
   } origin_type;

   typedef enum logic [2:0] {
      BK_CLEAR = 3'd0,
      BK_IDLE  = 3'd1,
      BK_READ  = 3'd2,
      BK_EVAL  = 3'd3,
      BK_EMIT  = 3'd4
   } back_state_type;

endpackage

>>> rtl/vfc_if.sv
// ----------------------------------------------------------------------------
// vfc_if
// Channel interfaces: request, response and register write channel.
// ----------------------------------------------------------------------------
interface vfc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [vfc_pkg::CRD_W-1:0]   cell_x;
   logic [vfc_pkg::CRD_W-1:0]   cell_y;
   logic [vfc_pkg::CRD_W-1:0]   cell_z;
   logic                        is_solid;
   logic [vfc_pkg::BTYPE_W-1:0] block_type;

   modport source (output valid, req_type, cell_x, cell_y, cell_z, is_solid, block_type,
                   input ready);
   modport sink   (input valid, req_type, cell_x, cell_y, cell_z, is_solid, block_type,
                   output ready);
endinterface

interface vfc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [vfc_pkg::WORD_W-1:0] world_x;
   logic signed [vfc_pkg::WORD_W-1:0] world_y;
   logic signed [vfc_pkg::WORD_W-1:0] world_z;
   logic [vfc_pkg::FACE_W-1:0]        face;
   logic [vfc_pkg::BTYPE_W-1:0]       face_block;
   logic                              last;

   modport source (output valid, world_x, world_y, world_z, face, face_block, last,
                   input ready);
   modport sink   (input valid, world_x, world_y, world_z, face, face_block, last,
                   output ready);
endinterface

interface vfc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [vfc_pkg::CSR_IDX_W-1:0] index;
   logic [vfc_pkg::WORD_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/vfc_front.sv
// ----------------------------------------------------------------------------
// vfc_front
// Accepts request transactions, drops out-of-chunk cells, computes the cell
// index and the boundary flags of the six faces, and queues the item.
// ----------------------------------------------------------------------------
module vfc_front #(
   parameter int DIM_X = vfc_pkg::DIM_X_DEF,
   parameter int DIM_Y = vfc_pkg::DIM_Y_DEF,
   parameter int DIM_Z = vfc_pkg::DIM_Z_DEF
) (
   input  logic              clock,
   input  logic              reset,
   vfc_req_if.sink           req,
   input  logic              clearing,
   output logic              q_valid,
   input  logic              q_ready,
   output vfc_pkg::item_type q_data
);

   logic in_range;
   int   cx;
   int   cy;
   int   cz;

   assign cx = int'(req.cell_x);
   assign cy = int'(req.cell_y);
   assign cz = int'(req.cell_z);

   assign in_range  = (cx < DIM_X) && (cy < DIM_Y) && (cz < DIM_Z);
   assign req.ready = q_ready && !clearing;
   // out-of-chunk items are taken and dropped here
   assign q_valid   = req.valid && req.ready && in_range;

   always_comb begin
      q_data.op       = vfc_pkg::op_type'(req.req_type);
      q_data.idx      = vfc_pkg::IDX_MAX_W'(cx + DIM_X * cy + DIM_X * DIM_Y * cz);
      q_data.x        = req.cell_x;
      q_data.y        = req.cell_y;
      q_data.z        = req.cell_z;
      q_data.solid    = req.is_solid;
      q_data.btype    = req.block_type;
      q_data.on_bound = {(cz == DIM_Z - 1), (cz == 0),
                         (cy == DIM_Y - 1), (cy == 0),
                         (cx == DIM_X - 1), (cx == 0)};
   end

   // a dropped item must never reach the queue
   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (req.valid && req.ready && in_range))
      else $error("front pushed an item that was not accepted or out of range");

endmodule

>>> rtl/vfc_fifo.sv
// ----------------------------------------------------------------------------
// vfc_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module vfc_fifo #(
   parameter int DEPTH = vfc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  vfc_pkg::item_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output vfc_pkg::item_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);

   vfc_pkg::item_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH))
      else $error("queue count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0])
      else $error("queue pointers disagree with count");

   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (PTR_W+1)'(DEPTH)) && !pop |=> count_ff == (PTR_W+1)'(DEPTH))
      else $error("full queue changed without a pop");

endmodule

>>> rtl/vfc_back.sv
// ----------------------------------------------------------------------------
// vfc_back
// Owns the solid and type maps. Executes writes, and for queries reads the
// cell and its six neighbors two at a time, then emits the visible faces.
// ----------------------------------------------------------------------------
module vfc_back #(
   parameter int DIM_X = vfc_pkg::DIM_X_DEF,
   parameter int DIM_Y = vfc_pkg::DIM_Y_DEF,
   parameter int DIM_Z = vfc_pkg::DIM_Z_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  vfc_pkg::origin_type origin,
   input  logic                q_valid,
   output logic                q_ready,
   input  vfc_pkg::item_type   q_data,
   output logic                clearing,
   vfc_rsp_if.source           rsp
);

   localparam int CELLS     = DIM_X * DIM_Y * DIM_Z;
   localparam int IDX_W     = $clog2(CELLS);
   localparam int STEP_Y    = DIM_X;
   localparam int STEP_Z    = DIM_X * DIM_Y;
   localparam int NF        = vfc_pkg::NUM_FACES;
   localparam int WORD_W    = vfc_pkg::WORD_W;
   localparam int BTYPE_W   = vfc_pkg::BTYPE_W;
   localparam int CRD_W     = vfc_pkg::CRD_W;
   localparam logic [2:0] READ_LAST = 3'd4;

   // cell maps
   logic                 solid_mem [CELLS];
   logic [BTYPE_W-1:0]   type_mem  [CELLS];

   vfc_pkg::back_state_type state_ff, state_in;
   logic [IDX_W-1:0]        clr_cnt_ff, clr_cnt_in;
   vfc_pkg::item_type       cur_ff, cur_in;
   logic [2:0]              step_ff, step_in;
   logic [NF:0]             sol_ff, sol_in;      // bit 0 self, bit f+1 neighbor of face f
   logic [NF-1:0]           vis_ff, vis_in;
   logic signed [WORD_W-1:0] wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;

   logic                    rd_a_ff, rd_b_ff;
   logic [BTYPE_W-1:0]      type_rd_ff;

   logic                    out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   vfc_pkg::face_type       out_face_ff, out_face_in;
   logic [BTYPE_W-1:0]      out_blk_ff, out_blk_in;
   logic                    out_last_ff, out_last_in;

   logic                    sol_we;
   logic [IDX_W-1:0]        sol_waddr;
   logic                    sol_wdata;
   logic                    type_we;
   logic [IDX_W-1:0]        addr_a;
   logic [IDX_W-1:0]        addr_b;
   logic [IDX_W-1:0]        cur_idx;
   logic [NF-1:0]           vis_now;
   logic                    load;
   logic [2:0]              pick;
   logic [NF-1:0]           rest;

   function automatic logic [IDX_W-1:0] slot_addr(input logic [2:0] slot,
                                                  input vfc_pkg::item_type it);
      logic [IDX_W-1:0] self_a;
      logic [IDX_W-1:0] a;
      self_a = IDX_W'(it.idx);
      a      = self_a;
      // boundary faces keep the cell's own address; their read is ignored
      if ((slot != 3'd0) && (slot <= 3'd6)) begin
         if (!it.on_bound[slot - 3'd1]) begin
            case (vfc_pkg::face_type'(slot - 3'd1))
               vfc_pkg::FACE_LEFT:   a = self_a - IDX_W'(1);
               vfc_pkg::FACE_RIGHT:  a = self_a + IDX_W'(1);
               vfc_pkg::FACE_BOTTOM: a = self_a - IDX_W'(STEP_Y);
               vfc_pkg::FACE_TOP:    a = self_a + IDX_W'(STEP_Y);
               vfc_pkg::FACE_BACK:   a = self_a - IDX_W'(STEP_Z);
               vfc_pkg::FACE_FRONT:  a = self_a + IDX_W'(STEP_Z);
               default:              a = self_a;
            endcase
         end
      end
      return a;
   endfunction

   assign cur_idx  = IDX_W'(cur_ff.idx);
   assign addr_a   = slot_addr({step_ff[1:0], 1'b0}, cur_ff);
   assign addr_b   = slot_addr({step_ff[1:0], 1'b1}, cur_ff);
   assign vis_now  = sol_ff[0] ? (cur_ff.on_bound | ~sol_ff[NF:1]) : '0;
   assign load     = !out_valid_ff || rsp.ready;
   assign clearing = (state_ff == vfc_pkg::BK_CLEAR);
   assign q_ready  = (state_ff == vfc_pkg::BK_IDLE);

   // lowest pending face goes first
   always_comb begin
      pick = 3'd0;
      for (int f = NF - 1; f >= 0; f--) begin
         if (vis_ff[f]) begin
            pick = 3'(f);
         end
      end
      rest       = vis_ff;
      rest[pick] = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfc_pkg::BK_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(CELLS - 1)) state_in = vfc_pkg::BK_IDLE;
         end
         vfc_pkg::BK_IDLE: begin
            if (q_valid && (q_data.op == vfc_pkg::OP_QUERY)) state_in = vfc_pkg::BK_READ;
         end
         vfc_pkg::BK_READ: begin
            if (step_ff == READ_LAST) state_in = vfc_pkg::BK_EVAL;
         end
         vfc_pkg::BK_EVAL: begin
            state_in = (vis_now != '0) ? vfc_pkg::BK_EMIT : vfc_pkg::BK_IDLE;
         end
         vfc_pkg::BK_EMIT: begin
            if (load && (rest == '0)) state_in = vfc_pkg::BK_IDLE;
         end
         default: state_in = vfc_pkg::BK_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      sol_in       = sol_ff;
      vis_in       = vis_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      wz_in        = wz_ff;
      sol_we       = 1'b0;
      sol_waddr    = IDX_W'(q_data.idx);
      sol_wdata    = q_data.solid;
      type_we      = 1'b0;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_face_in  = out_face_ff;
      out_blk_in   = out_blk_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         vfc_pkg::BK_CLEAR: begin
            sol_we     = 1'b1;
            sol_waddr  = clr_cnt_ff;
            sol_wdata  = 1'b0;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
         end
         vfc_pkg::BK_IDLE: begin
            step_in = 3'd0;
            if (q_valid) begin
               cur_in = q_data;
               if (q_data.op == vfc_pkg::OP_WRITE) begin
                  sol_we  = 1'b1;
                  type_we = 1'b1;
               end
            end
         end
         vfc_pkg::BK_READ: begin
            step_in = step_ff + 3'd1;
            // read data for an issued slot pair arrives in the next cycle
            case (step_ff)
               3'd1: begin sol_in[0] = rd_a_ff; sol_in[1] = rd_b_ff; end
               3'd2: begin sol_in[2] = rd_a_ff; sol_in[3] = rd_b_ff; end
               3'd3: begin sol_in[4] = rd_a_ff; sol_in[5] = rd_b_ff; end
               3'd4: begin sol_in[6] = rd_a_ff; end
               default: ;
            endcase
         end
         vfc_pkg::BK_EVAL: begin
            vis_in = vis_now;
            wx_in  = origin.x + $signed({{(WORD_W-CRD_W){1'b0}}, cur_ff.x});
            wy_in  = origin.y + $signed({{(WORD_W-CRD_W){1'b0}}, cur_ff.y});
            wz_in  = origin.z + $signed({{(WORD_W-CRD_W){1'b0}}, cur_ff.z});
         end
         vfc_pkg::BK_EMIT: begin
            if (load) begin
               out_valid_in = 1'b1;
               out_x_in     = wx_ff;
               out_y_in     = wy_ff;
               out_z_in     = wz_ff;
               out_face_in  = vfc_pkg::face_type'(pick);
               out_blk_in   = type_rd_ff;
               out_last_in  = (rest == '0);
               vis_in       = rest;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfc_pkg::BK_CLEAR;
         clr_cnt_ff   <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      sol_ff      <= sol_in;
      vis_ff      <= vis_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      wz_ff       <= wz_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_face_ff <= out_face_in;
      out_blk_ff  <= out_blk_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (sol_we) begin
         solid_mem[sol_waddr] <= sol_wdata;
      end
      rd_a_ff <= solid_mem[addr_a];
      rd_b_ff <= solid_mem[addr_b];
   end

   // type map needs no clearing: it is read only for cells whose solid bit was written
   always_ff @(posedge clock) begin
      if (type_we) begin
         type_mem[IDX_W'(q_data.idx)] <= q_data.btype;
      end
      type_rd_ff <= type_mem[cur_idx];
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.world_x    = out_x_ff;
   assign rsp.world_y    = out_y_ff;
   assign rsp.world_z    = out_z_ff;
   assign rsp.face       = out_face_ff;
   assign rsp.face_block = out_blk_ff;
   assign rsp.last       = out_last_ff;

   a_emit_has_face: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vfc_pkg::BK_EMIT) |-> (vis_ff != '0))
      else $error("emit phase with no pending face");

   a_emit_solid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vfc_pkg::BK_EMIT) |-> sol_ff[0])
      else $error("faces emitted for a cell that is not solid");

   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == vfc_pkg::BK_CLEAR) |-> ($past(clr_cnt_ff) == IDX_W'(CELLS - 1)))
      else $error("clearing pass left early");

   a_last_ends_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vfc_pkg::BK_EMIT) && load && (rest == '0)
         |=> (state_ff == vfc_pkg::BK_IDLE) && out_valid_ff && out_last_ff)
      else $error("last face did not close the query");

endmodule

>>> rtl/voxel_face_culler.sv
// ----------------------------------------------------------------------------
// voxel_face_culler
// Voxel chunk store with visible-face extraction. A write stores one cell's
// solid flag and block type; a query on a solid cell returns one response per
// visible face (left, right, bottom, top, back, front), with world position
// = origin register + cell coordinates and the last face marked. After reset
// the solid map is swept clear, one cell per cycle; requests are held off
// during the sweep, register writes are taken. The front takes one request
// per cycle, while the queue has room, into a 4-entry queue. The back takes
// a write in its dequeue step; a query goes through a dequeue step, a read
// phase that fetches the cell and its six neighbors through the two read
// ports of the solid map, an evaluate step, then one response per visible
// face, one per cycle while the response channel is ready; a non-solid or
// enclosed cell has none. Cells outside the chunk are accepted and dropped.
// ----------------------------------------------------------------------------
module voxel_face_culler #(
   parameter int DIM_X = vfc_pkg::DIM_X_DEF,
   parameter int DIM_Y = vfc_pkg::DIM_Y_DEF,
   parameter int DIM_Z = vfc_pkg::DIM_Z_DEF
) (
   input logic        clock,
   input logic        reset,
   vfc_req_if.sink    req_bus,
   vfc_rsp_if.source  rsp_bus,
   vfc_csr_if.sink    csr_bus
);

   vfc_pkg::origin_type origin_ff, origin_in;
   logic                clearing;
   logic                push_valid;
   logic                push_ready;
   vfc_pkg::item_type   push_data;
   logic                pop_valid;
   logic                pop_ready;
   vfc_pkg::item_type   pop_data;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      origin_in = origin_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            vfc_pkg::CSR_ORIGIN_X: origin_in.x = $signed(csr_bus.data);
            vfc_pkg::CSR_ORIGIN_Y: origin_in.y = $signed(csr_bus.data);
            vfc_pkg::CSR_ORIGIN_Z: origin_in.z = $signed(csr_bus.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
      end else begin
         origin_ff <= origin_in;
      end
   end

   vfc_front #(
      .DIM_X (DIM_X),
      .DIM_Y (DIM_Y),
      .DIM_Z (DIM_Z)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .clearing (clearing),
      .q_valid  (push_valid),
      .q_ready  (push_ready),
      .q_data   (push_data)
   );

   vfc_fifo #(
      .DEPTH (vfc_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vfc_back #(
      .DIM_X (DIM_X),
      .DIM_Y (DIM_Y),
      .DIM_Z (DIM_Z)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .origin   (origin_ff),
      .q_valid  (pop_valid),
      .q_ready  (pop_ready),
      .q_data   (pop_data),
      .clearing (clearing),
      .rsp      (rsp_bus)
   );

endmodule
